### rtl/core/stb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Types and constants of the sphere triangle bisector unit.
// ----------------------------------------------------------------------------
package stb_pkg;

    typedef enum logic {
        OP_BISECT  = 1'b0,
        OP_PROJECT = 1'b1
    } stb_op_t;

    typedef struct packed {
        stb_op_t            opcode;
        logic signed [31:0] in_a_x;
        logic signed [31:0] in_a_y;
        logic signed [31:0] in_a_z;
        logic signed [31:0] in_b_x;
        logic signed [31:0] in_b_y;
        logic signed [31:0] in_b_z;
        logic signed [31:0] in_c_x;
        logic signed [31:0] in_c_y;
        logic signed [31:0] in_c_z;
    } stb_in_t;

    typedef struct packed {
        logic signed [31:0] out_p_x;
        logic signed [31:0] out_p_y;
        logic signed [31:0] out_p_z;
        logic signed [31:0] out_q_x;
        logic signed [31:0] out_q_y;
        logic signed [31:0] out_q_z;
        logic signed [31:0] out_r_x;
        logic signed [31:0] out_r_y;
        logic signed [31:0] out_r_z;
        logic               last_of_run;
    } stb_out_t;

    // restoring divider state: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [65:0] rem;
        logic [63:0] dq;
    } stb_div_state_t;

    // restoring square root state
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] x;
    } stb_sqrt_state_t;

    localparam int NUM_VECS    = 3;
    localparam int NUM_AXES    = 3;
    localparam int NUM_LANES   = NUM_VECS * NUM_AXES;
    localparam int DIV_STEPS   = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_BASE    = 4;
    localparam int SQRT_BASE   = DIV_BASE + DIV_STEPS;
    localparam int PIPE_STAGES = SQRT_BASE + SQRT_STEPS;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic [31:0] POS_MAX      = 32'h7fff_ffff;

endpackage

### rtl/core/sphere_triangle_bisector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_triangle_bisector_unit
// Bisects a triangle edge onto a sphere, or projects a triangle onto it.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one triangle word (opcode plus vertices A, B,
//   C in signed Q16.16). m_valid/m_ready/m_data deliver triangle words.
//   Bisect gives (B, C, M) then (A, C, M) with last_of_run set on the second;
//   project gives (A', B', C') with last_of_run set.
//   cfg_valid/cfg_ready/cfg_data write the sphere radius; write it only while
//   no word is in flight. cfg_ready is always high.
// Pipeline: 100 stages, the 64-step divider the longest part, plus the
//   output register.
// Throughput: one project word per cycle while m_ready is high; a bisect word
//   holds the single result channel until both its triangles have gone out.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets the
//   radius to 1.0.
// Stall: while the output word waits (m_ready low, or first of a bisect pair)
//   and the last stage is full, the whole pipeline holds and s_ready goes low;
//   nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module sphere_triangle_bisector_unit
    import stb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  stb_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output stb_out_t    m_data
);

    logic [30:0]            radius_reg;
    logic [30:0]            radius_next;
    logic [PIPE_STAGES:1]   valid_reg;
    logic [PIPE_STAGES:1]   valid_next;

    stb_in_t                raw_reg   [1:PIPE_STAGES];
    logic [NUM_LANES-1:0]   neg_reg   [1:PIPE_STAGES];
    logic [NUM_LANES-1:0]   zero_reg  [1:PIPE_STAGES];
    logic [NUM_LANES-1:0]   neg_next;
    logic [NUM_LANES-1:0]   zero_next;

    logic [32:0]            mag_reg   [0:NUM_LANES-1];
    logic [32:0]            mag_next  [0:NUM_LANES-1];
    logic [65:0]            sq_reg    [0:NUM_LANES-1];
    logic [65:0]            sq_next   [0:NUM_LANES-1];
    logic [63:0]            u_reg     [0:NUM_LANES-1];
    logic [63:0]            u_next    [0:NUM_LANES-1];
    logic [65:0]            ssum_reg  [0:NUM_VECS-1];
    logic [65:0]            ssum_next [0:NUM_VECS-1];
    logic [63:0]            hh_reg    [0:NUM_LANES-1];
    logic [63:0]            hl_reg    [0:NUM_LANES-1];
    logic [63:0]            lh_reg    [0:NUM_LANES-1];
    logic [63:0]            ll_reg    [0:NUM_LANES-1];
    logic [63:0]            hh_next   [0:NUM_LANES-1];
    logic [63:0]            hl_next   [0:NUM_LANES-1];
    logic [63:0]            lh_next   [0:NUM_LANES-1];
    logic [63:0]            ll_next   [0:NUM_LANES-1];

    stb_div_state_t         div_reg   [0:DIV_STEPS][0:NUM_LANES-1];
    stb_div_state_t         div_next  [0:DIV_STEPS][0:NUM_LANES-1];
    logic [65:0]            dvs_reg   [0:DIV_STEPS-1][0:NUM_VECS-1];
    stb_sqrt_state_t        sqrt_reg  [1:SQRT_STEPS][0:NUM_LANES-1];
    stb_sqrt_state_t        sqrt_next [1:SQRT_STEPS][0:NUM_LANES-1];

    logic                   out_v_reg;
    logic                   out_v_next;
    logic                   out_phase_reg;
    logic                   out_phase_next;
    stb_in_t                out_raw_reg;
    logic [31:0]            out_res_reg  [0:NUM_LANES-1];
    logic [31:0]            out_res_next [0:NUM_LANES-1];

    logic                   last_word;
    logic                   out_pop;
    logic                   pipe_adv;
    logic                   out_load;

    function automatic stb_div_state_t div_step(stb_div_state_t st, logic [65:0] dvs);
        logic [66:0]    trial;
        stb_div_state_t res;
        trial   = {st.rem, st.dq[63]};
        res.dq  = {st.dq[62:0], 1'b0};
        res.rem = trial[65:0];
        if (trial >= {1'b0, dvs}) begin
            res.rem   = 66'(trial - {1'b0, dvs});
            res.dq[0] = 1'b1;
        end
        return res;
    endfunction

    function automatic stb_sqrt_state_t sqrt_step(stb_sqrt_state_t st);
        logic [35:0]     r;
        logic [35:0]     trial;
        stb_sqrt_state_t res;
        r        = {st.rem, st.x[63:62]};
        trial    = {2'b00, st.root, 2'b01};
        res.x    = {st.x[61:0], 2'b00};
        res.rem  = r[33:0];
        res.root = {st.root[30:0], 1'b0};
        if (r >= trial) begin
            res.rem     = 34'(r - trial);
            res.root[0] = 1'b1;
        end
        return res;
    endfunction

    // ---------------- control ----------------
    assign cfg_ready = 1'b1;
    assign last_word = (out_raw_reg.opcode == OP_PROJECT) || out_phase_reg;
    assign out_pop   = out_v_reg && m_ready && last_word;
    assign pipe_adv  = !valid_reg[PIPE_STAGES] || !out_v_reg || out_pop;
    assign out_load  = pipe_adv && valid_reg[PIPE_STAGES];
    assign s_ready   = pipe_adv;
    assign m_valid   = out_v_reg;

    always_comb begin
        radius_next    = radius_reg;
        valid_next     = valid_reg;
        out_v_next     = out_v_reg;
        out_phase_next = out_phase_reg;
        if (cfg_valid) begin
            radius_next = cfg_data;
        end
        if (pipe_adv) begin
            valid_next = {valid_reg[PIPE_STAGES-1:1], s_valid};
        end
        if (out_load) begin
            out_v_next     = 1'b1;
            out_phase_next = 1'b0;
        end else if (out_pop) begin
            out_v_next = 1'b0;
        end else if (out_v_reg && m_ready) begin
            out_phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= RADIUS_RESET;
            valid_reg     <= '0;
            out_v_reg     <= 1'b0;
            out_phase_reg <= 1'b0;
        end else begin
            radius_reg    <= radius_next;
            valid_reg     <= valid_next;
            out_v_reg     <= out_v_next;
            out_phase_reg <= out_phase_next;
        end
    end

    // ---------------- datapath ----------------
    always_comb begin : front_comb
        logic signed [31:0] a_in [0:NUM_AXES-1];
        logic signed [31:0] b_in [0:NUM_AXES-1];
        logic signed [31:0] c_in [0:NUM_AXES-1];
        logic signed [32:0] vin  [0:NUM_LANES-1];
        logic [31:0]        uh;
        logic [31:0]        ul;
        a_in[0] = s_data.in_a_x;
        a_in[1] = s_data.in_a_y;
        a_in[2] = s_data.in_a_z;
        b_in[0] = s_data.in_b_x;
        b_in[1] = s_data.in_b_y;
        b_in[2] = s_data.in_b_z;
        c_in[0] = s_data.in_c_x;
        c_in[1] = s_data.in_c_y;
        c_in[2] = s_data.in_c_z;
        for (int c = 0; c < NUM_AXES; c++) begin
            // bisect scales the unhalved sum A+B, which has the same direction
            if (s_data.opcode == OP_PROJECT) begin
                vin[c] = 33'(a_in[c]);
            end else begin
                vin[c] = 33'(a_in[c]) + 33'(b_in[c]);
            end
            vin[NUM_AXES + c]   = 33'(b_in[c]);
            vin[2*NUM_AXES + c] = 33'(c_in[c]);
        end
        for (int l = 0; l < NUM_LANES; l++) begin
            neg_next[l]  = vin[l][32];
            zero_next[l] = (vin[l] == '0);
            mag_next[l]  = vin[l][32] ? 33'(-vin[l]) : 33'(vin[l]);
            sq_next[l]   = 66'(mag_reg[l]) * 66'(mag_reg[l]);
            u_next[l]    = 64'(mag_reg[l]) * 64'(radius_reg);
            uh           = u_reg[l][63:32];
            ul           = u_reg[l][31:0];
            hh_next[l]   = 64'(uh) * 64'(uh);
            hl_next[l]   = 64'(uh) * 64'(ul);
            lh_next[l]   = 64'(ul) * 64'(uh);
            ll_next[l]   = 64'(ul) * 64'(ul);
        end
        for (int v = 0; v < NUM_VECS; v++) begin
            ssum_next[v] = sq_reg[NUM_AXES*v] + sq_reg[NUM_AXES*v + 1]
                         + sq_reg[NUM_AXES*v + 2];
        end
    end

    always_comb begin : core_comb
        logic [127:0] usq;
        logic [129:0] tt;
        for (int l = 0; l < NUM_LANES; l++) begin
            // T = 4 * (v*R)^2; quotient T/S is below 2^64, so the top part
            // already sits below S and seeds the remainder
            usq = {hh_reg[l], ll_reg[l]}
                + (128'(65'(hl_reg[l]) + 65'(lh_reg[l])) << 32);
            tt  = {usq, 2'b00};
            div_next[0][l].rem = tt[129:64];
            div_next[0][l].dq  = tt[63:0];
            for (int j = 1; j <= DIV_STEPS; j++) begin
                div_next[j][l] = div_step(div_reg[j-1][l], dvs_reg[j-1][l / NUM_AXES]);
            end
            sqrt_next[1][l] = sqrt_step('{rem: '0, root: '0, x: div_reg[DIV_STEPS][l].dq});
            for (int k = 2; k <= SQRT_STEPS; k++) begin
                sqrt_next[k][l] = sqrt_step(sqrt_reg[k-1][l]);
            end
        end
    end

    always_comb begin : result_comb
        logic [31:0] half;
        for (int l = 0; l < NUM_LANES; l++) begin
            // largest odd 2m-1 not above isqrt(Q), ties away from zero
            half = 32'((33'(sqrt_reg[SQRT_STEPS][l].root) + 33'd1) >> 1);
            if (zero_reg[PIPE_STAGES][l]) begin
                out_res_next[l] = '0;
            end else if (neg_reg[PIPE_STAGES][l]) begin
                out_res_next[l] = 32'(-half);
            end else if (half > POS_MAX) begin
                out_res_next[l] = POS_MAX;
            end else begin
                out_res_next[l] = half;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            raw_reg[1]  <= s_data;
            neg_reg[1]  <= neg_next;
            zero_reg[1] <= zero_next;
            for (int st = 2; st <= PIPE_STAGES; st++) begin
                raw_reg[st]  <= raw_reg[st-1];
                neg_reg[st]  <= neg_reg[st-1];
                zero_reg[st] <= zero_reg[st-1];
            end
            for (int l = 0; l < NUM_LANES; l++) begin
                mag_reg[l] <= mag_next[l];
                sq_reg[l]  <= sq_next[l];
                u_reg[l]   <= u_next[l];
                hh_reg[l]  <= hh_next[l];
                hl_reg[l]  <= hl_next[l];
                lh_reg[l]  <= lh_next[l];
                ll_reg[l]  <= ll_next[l];
                for (int j = 0; j <= DIV_STEPS; j++) begin
                    div_reg[j][l] <= div_next[j][l];
                end
                for (int k = 1; k <= SQRT_STEPS; k++) begin
                    sqrt_reg[k][l] <= sqrt_next[k][l];
                end
            end
            for (int v = 0; v < NUM_VECS; v++) begin
                ssum_reg[v]   <= ssum_next[v];
                dvs_reg[0][v] <= ssum_reg[v];
                for (int j = 1; j < DIV_STEPS; j++) begin
                    dvs_reg[j][v] <= dvs_reg[j-1][v];
                end
            end
        end
        if (out_load) begin
            out_raw_reg <= raw_reg[PIPE_STAGES];
            for (int l = 0; l < NUM_LANES; l++) begin
                out_res_reg[l] <= out_res_next[l];
            end
        end
    end

    // ---------------- output word ----------------
    always_comb begin
        if (out_raw_reg.opcode == OP_PROJECT) begin
            m_data.out_p_x = out_res_reg[0];
            m_data.out_p_y = out_res_reg[1];
            m_data.out_p_z = out_res_reg[2];
            m_data.out_q_x = out_res_reg[3];
            m_data.out_q_y = out_res_reg[4];
            m_data.out_q_z = out_res_reg[5];
        end else if (!out_phase_reg) begin
            m_data.out_p_x = out_raw_reg.in_b_x;
            m_data.out_p_y = out_raw_reg.in_b_y;
            m_data.out_p_z = out_raw_reg.in_b_z;
            m_data.out_q_x = out_raw_reg.in_c_x;
            m_data.out_q_y = out_raw_reg.in_c_y;
            m_data.out_q_z = out_raw_reg.in_c_z;
        end else begin
            m_data.out_p_x = out_raw_reg.in_a_x;
            m_data.out_p_y = out_raw_reg.in_a_y;
            m_data.out_p_z = out_raw_reg.in_a_z;
            m_data.out_q_x = out_raw_reg.in_c_x;
            m_data.out_q_y = out_raw_reg.in_c_y;
            m_data.out_q_z = out_raw_reg.in_c_z;
        end
        if (out_raw_reg.opcode == OP_PROJECT) begin
            m_data.out_r_x = out_res_reg[6];
            m_data.out_r_y = out_res_reg[7];
            m_data.out_r_z = out_res_reg[8];
        end else begin
            m_data.out_r_x = out_res_reg[0];
            m_data.out_r_y = out_res_reg[1];
            m_data.out_r_z = out_res_reg[2];
        end
        m_data.last_of_run = last_word;
    end

    // ---------------- assertions ----------------
    // the first bisect word is always followed by its last word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_of_run) |=> (m_valid && m_data.last_of_run))
        else $error("bisect pair broken");

    // input backpressure only comes from a held output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && valid_reg[PIPE_STAGES]))
        else $error("pipeline stalled without output backpressure");

    // the first scaled component (lane 0) never exceeds the radius in magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> (($signed(out_res_reg[0]) <= $signed({1'b0, radius_reg}))
                    && ($signed(out_res_reg[0]) >= -$signed({1'b0, radius_reg}))))
        else $error("scaled component beyond radius");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sphere_triangle_bisector_unit: directed and random
// triangles under several radius settings, with random gaps on both sides,
// compared word by word against an exact integer predictor.
// ----------------------------------------------------------------------------
module tb
    import stb_pkg::*;
();

    typedef logic signed [33:0] wide_t;

    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    stb_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    stb_out_t    m_data;

    stb_out_t    expected_tris[$];
    logic [30:0] radius_now;
    int          mismatches = 0;
    int          hold_requests = 0;
    bit          holding;
    bit          steady_in;
    bit          steady_out;

    sphere_triangle_bisector_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // exact v * r / |v|, rounded half away from zero, found by bisection
    function automatic logic [31:0] scale_axis(wide_t v, logic [159:0] ss, logic [30:0] r);
        logic [33:0]  mag;
        logic [32:0]  lo;
        logic [32:0]  hi;
        logic [32:0]  mid;
        logic [33:0]  d;
        logic [159:0] lim;
        mag = (v < 0) ? 34'(-v) : 34'(v);
        if (mag == 0)
            return 32'd0;
        lim = 160'(mag) * 160'(mag) * 160'(r) * 160'(r) * 160'd4;
        lo = '0;
        hi = 33'h0_8000_0000;
        while (lo < hi) begin
            mid = (lo + hi + 33'd1) >> 1;
            d = 34'(mid) * 34'd2 - 34'd1;
            if (160'(d) * 160'(d) * ss <= lim)
                lo = mid;
            else
                hi = mid - 33'd1;
        end
        if (v < 0)
            return -lo[31:0];
        if (lo > 33'h0_7fff_ffff)
            lo = 33'h0_7fff_ffff;
        return lo[31:0];
    endfunction

    task automatic push_to_sphere(input wide_t x, input wide_t y, input wide_t z,
                                  output logic [31:0] ox, output logic [31:0] oy,
                                  output logic [31:0] oz);
        logic [159:0] ss;
        logic [33:0]  mx;
        logic [33:0]  my;
        logic [33:0]  mz;
        mx = (x < 0) ? 34'(-x) : 34'(x);
        my = (y < 0) ? 34'(-y) : 34'(y);
        mz = (z < 0) ? 34'(-z) : 34'(z);
        ss = 160'(mx) * 160'(mx) + 160'(my) * 160'(my) + 160'(mz) * 160'(mz);
        if (ss == 0) begin
            ox = '0; oy = '0; oz = '0;
        end else begin
            ox = scale_axis(x, ss, radius_now);
            oy = scale_axis(y, ss, radius_now);
            oz = scale_axis(z, ss, radius_now);
        end
    endtask

    task automatic predict_triangles(input stb_in_t w);
        stb_out_t t;
        logic [31:0] mx, my, mz;
        if (w.opcode == OP_BISECT) begin
            push_to_sphere(wide_t'(w.in_a_x) + wide_t'(w.in_b_x),
                           wide_t'(w.in_a_y) + wide_t'(w.in_b_y),
                           wide_t'(w.in_a_z) + wide_t'(w.in_b_z), mx, my, mz);
            t = '{w.in_b_x, w.in_b_y, w.in_b_z, w.in_c_x, w.in_c_y, w.in_c_z,
                  mx, my, mz, 1'b0};
            expected_tris.insert(expected_tris.size(), t);
            t.out_p_x = w.in_a_x;
            t.out_p_y = w.in_a_y;
            t.out_p_z = w.in_a_z;
            t.last_of_run = 1'b1;
            expected_tris.insert(expected_tris.size(), t);
        end else begin
            push_to_sphere(wide_t'(w.in_a_x), wide_t'(w.in_a_y), wide_t'(w.in_a_z),
                           t.out_p_x, t.out_p_y, t.out_p_z);
            push_to_sphere(wide_t'(w.in_b_x), wide_t'(w.in_b_y), wide_t'(w.in_b_z),
                           t.out_q_x, t.out_q_y, t.out_q_z);
            push_to_sphere(wide_t'(w.in_c_x), wide_t'(w.in_c_y), wide_t'(w.in_c_z),
                           t.out_r_x, t.out_r_y, t.out_r_z);
            t.last_of_run = 1'b1;
            expected_tris.insert(expected_tris.size(), t);
        end
    endtask

    function automatic int draw_gap(bit steady);
        return steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    endfunction

    // long receiver hold-off, started from the test sequence
    initial begin : hold_off
        int served;
        served = 0;
        forever begin
            @(posedge aclk);
            if (served != hold_requests) begin
                served++;
                holding <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holding <= 1'b0;
            end
        end
    end

    // result side: per-word stall draws plus the long hold-off
    initial begin : result_check
        int       stall;
        stb_out_t e;
        bit       bad;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_tris.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", m_data);
                end else begin
                    e = expected_tris.pop_front();
                    bad = 1'b0;
                    for (int i = 0; i < 9; i++)
                        if (m_data[288 - 32 * i -: 32] !== e[288 - 32 * i -: 32]) bad = 1'b1;
                    if (m_data.last_of_run !== e.last_of_run) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", e, m_data);
                    end
                end
                stall = draw_gap(steady_out);
            end
            if (holding) begin
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input stb_in_t w);
        int gap;
        gap = draw_gap(steady_in);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_triangles(w);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        wait (expected_tris.size() == 0);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [30:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_now = r;
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 1 << 20);
            1: case ($urandom_range(0, 3))
                   0: v = 32'h8000_0000;
                   1: v = 32'h7fff_ffff;
                   2: v = 32'h0;
                   default: v = 32'hffff_ffff;
               endcase
            2: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic stb_in_t pick_triangle();
        stb_in_t w;
        w.opcode = stb_op_t'($urandom_range(0, 1));
        w.in_a_x = pick_coord(); w.in_a_y = pick_coord(); w.in_a_z = pick_coord();
        w.in_b_x = pick_coord(); w.in_b_y = pick_coord(); w.in_b_z = pick_coord();
        w.in_c_x = pick_coord(); w.in_c_y = pick_coord(); w.in_c_z = pick_coord();
        // opposite endpoints give a zero midpoint
        if ($urandom_range(0, 19) == 0) begin
            w.in_b_x = -w.in_a_x; w.in_b_y = -w.in_a_y; w.in_b_z = -w.in_a_z;
        end
        return w;
    endfunction

    function automatic stb_in_t flat_triangle(stb_op_t op, logic [31:0] a,
                                              logic [31:0] b, logic [31:0] c);
        return '{op, a, a, a, b, b, b, c, c, c};
    endfunction

    task automatic test_directed;
        steady_in = 1'b0;
        steady_out = 1'b0;
        for (int k = 0; k < 2; k++) begin
            stb_op_t op;
            op = stb_op_t'(k);
            send_word(flat_triangle(op, 32'h0, 32'h0, 32'h0));
            send_word(flat_triangle(op, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
            send_word(flat_triangle(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
            send_word(flat_triangle(op, 32'h0001_0000, 32'hffff_0000, 32'h0000_0001));
            send_word(flat_triangle(op, 32'h7fff_ffff, 32'h8000_0001, 32'hffff_ffff));
            send_word('{op, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
                        32'h0, 32'h0, 32'hffff_0000});
            send_word('{op, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h8000_0000,
                        32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0});
        end
    endtask

    task automatic test_radius_sweep;
        logic [30:0] radii[5];
        radii = '{31'd0, 31'h7fff_ffff, 31'd1, 31'($urandom), 31'd65536};
        foreach (radii[i]) begin
            write_radius(radii[i]);
            for (int n = 0; n < 6; n++)
                send_word(flat_triangle(stb_op_t'(n & 1), pick_coord(), pick_coord(),
                                        32'h8000_0000));
            for (int n = 0; n < 250; n++)
                send_word(pick_triangle());
        end
    endtask

    task automatic test_back_pressure;
        steady_in = 1'b1;
        steady_out = 1'b1;
        drain();
        hold_requests++;
        for (int n = 0; n < 250; n++)
            send_word(pick_triangle());
        // sender waits for the pipeline to empty, then full rate both ways
        s_valid <= 1'b0;
        wait (expected_tris.size() == 0);
        for (int n = 0; n < 100; n++)
            send_word(pick_triangle());
        steady_in = 1'b0;
        steady_out = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        radius_now = RADIUS_RESET;
        steady_in = 1'b0;
        steady_out = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_radius_sweep();
        test_back_pressure();
        write_radius(31'($urandom_range(1, 1 << 24)));
        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
